@@ rtl/kts_pkg.sv @@
// Package: types, constants and move tables for the knight's tour search core.
package kts_pkg;

    localparam int MAX_SIDE = 8;
    localparam int NSQ      = 64;

    localparam logic CFG_BOARD_SIDE = 1'b0;
    localparam logic CFG_STEP_LIMIT = 1'b1;

    localparam logic [1:0] ST_TOUR   = 2'd0;
    localparam logic [1:0] ST_NOTOUR = 2'd1;
    localparam logic [1:0] ST_LIMIT  = 2'd2;
    localparam logic [1:0] ST_OFFB   = 2'd3;

    typedef struct packed {
        logic [2:0] start_row;
        logic [2:0] start_col;
    } t_in;

    typedef struct packed {
        logic [2:0] row;
        logic [2:0] col;
        logic [5:0] step_index;
        logic [1:0] status;
        logic       last;
    } t_out;

    // Target of move k from square sq; valid is low when off board.
    function automatic logic [6:0] move_target(input logic [5:0] sq, input logic [2:0] k,
                                               input logic [3:0] side);
        logic signed [4:0] r;
        logic signed [4:0] c;
        logic signed [4:0] dr;
        logic signed [4:0] dc;
        case (k)
            3'd0: begin dr = -5'sd2; dc =  5'sd1; end
            3'd1: begin dr = -5'sd1; dc =  5'sd2; end
            3'd2: begin dr =  5'sd1; dc =  5'sd2; end
            3'd3: begin dr =  5'sd2; dc =  5'sd1; end
            3'd4: begin dr =  5'sd2; dc = -5'sd1; end
            3'd5: begin dr =  5'sd1; dc = -5'sd2; end
            3'd6: begin dr = -5'sd1; dc = -5'sd2; end
            default: begin dr = -5'sd2; dc = -5'sd1; end
        endcase
        r = $signed({2'b00, sq[5:3]}) + dr;
        c = $signed({2'b00, sq[2:0]}) + dc;
        move_target = {(r >= 0) && (c >= 0) && (r < $signed({1'b0, side}))
                       && (c < $signed({1'b0, side})), r[2:0], c[2:0]};
    endfunction

endpackage

@@ rtl/kts_ram.sv @@
// Generic single-port-write, one-read synchronous RAM with registered read.
module kts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ rtl/knights_tour_search_core.sv @@
// Top level of the knight's tour search core.
// A transaction on the input channel carries a start square; the core then searches for an
// open knight's tour with Warnsdorff ordering and backtracking, and emits either one result
// per board square (status 0, last on the final square) or one result with status 1 (no
// tour), 2 (step limit reached) or 3 (start off board). One search runs at a time; input
// ready stays low until the last result of the search is loaded into the output register.
// Duration is data dependent: entering a square runs an entry step, the onward probes and
// scoring of each of the 8 moves in S_ENTER, and a wrap-up in S_EDONE; a backtrack step
// passes S_POPRD and S_POP, and the path readout S_OUTRD and S_OUT per square plus any
// output stall. The visited map lives in flip-flops cleared at search start; the path and
// candidate masks live in two synchronous RAMs whose registered read sets the backtrack
// and readout pace. The search depth is the stack pointer.
module knights_tour_search_core
    import kts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in         i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out        o_data
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_START = 4'd1;
    localparam logic [3:0] S_ENTER = 4'd2;  // scan moves k, probes j
    localparam logic [3:0] S_EDONE = 4'd3;
    localparam logic [3:0] S_POPRD = 4'd4;  // read mask/path at depth
    localparam logic [3:0] S_POP   = 4'd5;
    localparam logic [3:0] S_OUTRD = 4'd6;
    localparam logic [3:0] S_OUT   = 4'd7;
    localparam logic [3:0] S_ONE   = 4'd8;

    logic [3:0]  r_state, n_state;
    logic [3:0]  r_side;
    logic [31:0] r_limit;
    logic [31:0] r_steps;
    logic [NSQ-1:0] r_vis;
    logic [6:0]  r_d;        // depth of square being entered / stack top
    logic [5:0]  r_sq;       // square being entered
    logic [2:0]  r_k;
    logic [3:0]  r_j;        // 0 = entry, 1..8 probes, 9 = finish move k
    logic [3:0]  r_cnt;
    logic [3:0]  r_best;
    logic [7:0]  r_mask;
    logic [6:0]  r_oi;
    t_out        r_out;
    logic        r_ov;

    logic [3:0]  side;
    logic [6:0]  total;
    assign side  = (r_side == 4'd0) ? 4'd1 :
                   ((r_side > 4'(MAX_SIDE)) ? 4'(MAX_SIDE) : r_side);
    assign total = {3'd0, side} * {3'd0, side};

    // path and candidate-mask memories
    logic       p_we, m_we;
    logic [5:0] p_wa, m_wa, p_ra, m_ra;
    logic [5:0] p_wd, p_rd;
    logic [7:0] m_wd, m_rd;

    kts_ram #(.WIDTH(6), .DEPTH(NSQ)) u_path (
        .i_clk(i_clk), .i_we(p_we), .i_waddr(p_wa), .i_wdata(p_wd),
        .i_raddr(p_ra), .o_rdata(p_rd));
    kts_ram #(.WIDTH(8), .DEPTH(NSQ)) u_mask (
        .i_clk(i_clk), .i_we(m_we), .i_waddr(m_wa), .i_wdata(m_wd),
        .i_raddr(m_ra), .o_rdata(m_rd));

    // move target and onward probe
    logic [6:0] tk, tj;
    logic       tk_ok, tj_ok;
    assign tk    = move_target(r_sq, r_k, side);
    assign tk_ok = tk[6] && !r_vis[tk[5:0]];
    assign tj    = move_target(tk[5:0], r_j[2:0], side);
    assign tj_ok = tj[6] && !r_vis[tj[5:0]];

    // pop stage: lowest candidate of the mask read back
    logic [2:0] pk;
    logic [6:0] pt;
    always_comb begin
        pk = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (m_rd[i]) pk = 3'(i);
        end
    end
    assign pt = move_target(p_rd, pk, side);

    logic limit_hit, in_acc;
    assign limit_hit = (r_limit != 32'd0) && (r_steps >= r_limit);
    assign o_ready   = (r_state == S_IDLE);
    assign in_acc    = i_valid && o_ready;
    assign o_valid   = r_ov;
    assign o_data    = r_out;

    logic       o_free;
    logic       o_load;
    assign o_free = !r_ov || i_ready;
    // load a new result when the output register frees up in an emitting state
    assign o_load = o_free && (r_state == S_OUT || r_state == S_ONE);

    always_comb begin
        p_we = 1'b0; p_wa = r_d[5:0]; p_wd = r_sq;
        m_we = 1'b0; m_wa = r_d[5:0]; m_wd = r_mask;
        p_ra = r_d[5:0]; m_ra = r_d[5:0];
        if (r_state == S_ENTER && r_k == 3'd0 && r_j == 4'd0) p_we = 1'b1;
        if (r_state == S_EDONE && r_mask != 8'd0) m_we = 1'b1;
        if (r_state == S_POP && m_rd != 8'd0) begin
            m_we = 1'b1; m_wd = m_rd & ~(8'd1 << pk);
        end
        // hold the readout address while the output stalls
        if (r_state == S_OUTRD || r_state == S_OUT) p_ra = r_oi[5:0];
    end

    logic [1:0] r_onest;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_side  <= 4'd8;
            r_limit <= 32'd0;
            r_ov    <= 1'b0;
            r_vis   <= '0;
            r_d     <= '0;
            r_steps <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_BOARD_SIDE) r_side <= i_cfg_data[3:0];
                else r_limit <= i_cfg_data;
            end
            if (o_load) r_ov <= 1'b1;
            else if (r_ov && i_ready) r_ov <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_vis   <= '0;
                        r_steps <= '0;
                        r_d     <= '0;
                        r_sq    <= {i_data.start_row, i_data.start_col};
                        r_state <= S_START;
                    end
                end
                S_START: begin
                    if ({1'b0, r_sq[5:3]} >= side || {1'b0, r_sq[2:0]} >= side) begin
                        r_onest <= ST_OFFB; r_state <= S_ONE;
                    end else if (limit_hit) begin
                        r_onest <= ST_LIMIT; r_state <= S_ONE;
                    end else begin
                        r_state <= S_ENTER;
                        r_k <= '0; r_j <= '0;
                    end
                end
                S_ENTER: begin
                    if (r_k == 3'd0 && r_j == 4'd0) begin
                        r_vis[r_sq] <= 1'b1;
                        r_steps <= r_steps + 32'd1;
                        r_best  <= 4'd9; r_mask <= '0; r_cnt <= '0;
                        if (r_d + 7'd1 == total) begin
                            r_oi <= '0; r_state <= S_OUTRD;
                        end else begin
                            r_j <= 4'd1;
                        end
                    end else if (!tk_ok || r_j == 4'd9) begin
                        // close move k (probes j counted 1..8 use move j mod 8, so 8 maps to move 0)
                        if (tk_ok && !(r_cnt == 4'd0 && r_d + 7'd2 != total)) begin
                            if (r_cnt < r_best) begin
                                r_best <= r_cnt; r_mask <= 8'd1 << r_k;
                            end else if (r_cnt == r_best) begin
                                r_mask <= r_mask | (8'd1 << r_k);
                            end
                        end
                        r_cnt <= '0; r_j <= 4'd1;
                        if (r_k == 3'd7) r_state <= S_EDONE;
                        else r_k <= r_k + 3'd1;
                    end else begin
                        if (tj_ok) r_cnt <= r_cnt + 4'd1;
                        r_j <= r_j + 4'd1;
                    end
                end
                S_EDONE: begin
                    if (r_mask == 8'd0) begin
                        r_vis[r_sq] <= 1'b0;
                        if (r_d == 7'd0) begin
                            r_onest <= ST_NOTOUR; r_state <= S_ONE;
                        end else begin
                            r_d <= r_d - 7'd1; r_state <= S_POPRD;
                        end
                    end else begin
                        r_state <= S_POPRD;
                    end
                end
                S_POPRD: r_state <= S_POP;
                S_POP: begin
                    if (m_rd == 8'd0) begin
                        r_vis[p_rd] <= 1'b0;
                        if (r_d == 7'd0) begin
                            r_onest <= ST_NOTOUR; r_state <= S_ONE;
                        end else begin
                            r_d <= r_d - 7'd1; r_state <= S_POPRD;
                        end
                    end else if (!pt[6] || r_vis[pt[5:0]]) begin
                        r_state <= S_POPRD;
                    end else if (limit_hit) begin
                        r_onest <= ST_LIMIT; r_state <= S_ONE;
                    end else begin
                        // stack top moves up to the child at once; EDONE
                        // undoes on a dead end by stepping back to this depth
                        r_sq <= pt[5:0]; r_d <= r_d + 7'd1;
                        r_k <= '0; r_j <= '0; r_state <= S_ENTER;
                    end
                end
                S_OUTRD: r_state <= S_OUT;
                S_OUT: begin
                    if (o_free) begin
                        r_out.row <= p_rd[5:3]; r_out.col <= p_rd[2:0];
                        r_out.step_index <= r_oi[5:0];
                        r_out.status <= ST_TOUR;
                        r_out.last <= (r_oi + 7'd1 == total);
                        if (r_oi + 7'd1 == total) r_state <= S_IDLE;
                        else begin
                            r_oi <= r_oi + 7'd1; r_state <= S_OUTRD;
                        end
                    end
                end
                S_ONE: begin
                    if (o_free) begin
                        r_out <= '{row: 3'd0, col: 3'd0, step_index: 6'd0,
                                   status: r_onest, last: 1'b1};
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

@@ rtl/kts_checker.sv @@
// Port-level checker for the knight's tour search core, bound to the top level.
module kts_checker
    import kts_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_ready,
    input logic o_valid,
    input logic i_ready,
    input t_out o_data
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result changed while stalled");
    a_fail_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.status != ST_TOUR |-> o_data.last)
        else $error("failure result without last");
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.status != ST_TOUR |-> o_data.step_index == 6'd0)
        else $error("failure result with nonzero index");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second transaction accepted during search");
endmodule

bind knights_tour_search_core kts_checker u_kts_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data));

@@ test/tb.sv @@
// Testbench for the knight's tour search core: directed table, then random searches vs. a predictor.
module tb;
    import kts_pkg::*;

    localparam int CYCLE_LIMIT = 50000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = CFG_BOARD_SIDE;
    logic [31:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    t_in         i_data = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    t_out        o_data;

    knights_tour_search_core dut (.*);

    always #5 i_clk = ~i_clk;

    // Predictor state: its own copy of the configuration and the search stack.
    logic [3:0]  side_reg = 4'd8;
    logic [31:0] limit_reg = '0;
    logic        seen_sq [64];
    logic [5:0]  route [64];
    logic [7:0]  moves_left [64];
    logic [31:0] entered;

    t_out tour_q[$];
    int   errors = 0;
    int   n_results = 0;
    int   n_searches = 0;
    int   n_tours = 0;
    longint cyc = 0;
    bit   hold_req = 1'b0;

    // Target square of move k, or 64 when it leaves the board or is already visited.
    function automatic int hop(int sq, int k, int side);
        int dr[8] = '{-2, -1, 1, 2, 2, 1, -1, -2};
        int dc[8] = '{1, 2, 2, 1, -1, -2, -2, -1};
        int r;
        int c;
        r = sq / 8 + dr[k];
        c = sq % 8 + dc[k];
        if (r < 0 || c < 0 || r >= side || c >= side) return 64;
        if (seen_sq[r * 8 + c]) return 64;
        return r * 8 + c;
    endfunction

    // Enter a square: 1 tour complete, 0 dead end (undone), 2 candidates pending.
    function automatic int occupy(int sq, int d, int side);
        int best;
        int mask;
        int t;
        int a;
        best = 9;
        mask = 0;
        seen_sq[sq] = 1'b1;
        route[d] = sq[5:0];
        entered++;
        if (d + 1 == side * side) return 1;
        for (int k = 0; k < 8; k++) begin
            t = hop(sq, k, side);
            if (t < 64) begin
                a = 0;
                for (int j = 0; j < 8; j++) if (hop(t, j, side) < 64) a++;
                if (!(a == 0 && d + 1 != side * side - 1)) begin
                    if (a < best) begin
                        best = a;
                        mask = 1 << k;
                    end else if (a == best) begin
                        mask |= 1 << k;
                    end
                end
            end
        end
        if (mask == 0) begin
            seen_sq[sq] = 1'b0;
            return 0;
        end
        moves_left[d] = mask[7:0];
        return 2;
    endfunction

    function automatic t_out lone(logic [1:0] st);
        t_out o;
        o = '0;
        o.status = st;
        o.last = 1'b1;
        return o;
    endfunction

    function automatic bit limit_reached();
        return limit_reg != 0 && entered >= limit_reg;
    endfunction

    // Run the whole search for one start square and queue what the core must emit.
    task automatic predict_tour(t_in s);
        int side;
        int d;
        int res;
        int k;
        int t;
        t_out o;
        side = (side_reg == 0) ? 1 : (side_reg > MAX_SIDE) ? MAX_SIDE : side_reg;
        foreach (seen_sq[i]) seen_sq[i] = 1'b0;
        entered = 0;
        d = 0;
        if (s.start_row >= side || s.start_col >= side) begin
            tour_q.push_back(lone(ST_OFFB));
            return;
        end
        if (limit_reached()) begin
            tour_q.push_back(lone(ST_LIMIT));
            return;
        end
        res = occupy(s.start_row * 8 + s.start_col, 0, side);
        if (res == 0) begin
            tour_q.push_back(lone(ST_NOTOUR));
            return;
        end
        while (res != 1) begin
            if (moves_left[d] == 0) begin
                seen_sq[route[d]] = 1'b0;
                if (d == 0) begin
                    tour_q.push_back(lone(ST_NOTOUR));
                    return;
                end
                d--;
                continue;
            end
            k = 0;
            while (!moves_left[d][k]) k++;
            moves_left[d][k] = 1'b0;
            t = hop(route[d], k, side);
            if (t >= 64) continue;
            if (limit_reached()) begin
                tour_q.push_back(lone(ST_LIMIT));
                return;
            end
            res = occupy(t, d + 1, side);
            if (res == 2) d++;
        end
        n_tours++;
        for (int i = 0; i < side * side; i++) begin
            o.row = route[i][5:3];
            o.col = route[i][2:0];
            o.step_index = i[5:0];
            o.status = ST_TOUR;
            o.last = (i + 1 == side * side);
            tour_q.push_back(o);
        end
    endtask

    // Result checker: compare each transaction with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            n_results++;
            if (tour_q.size() == 0) begin
                $error("unexpected result row=%0d col=%0d status=%0d", o_data.row,
                       o_data.col, o_data.status);
                errors++;
            end else begin
                t_out e;
                e = tour_q.pop_front();
                if (o_data.row !== e.row) begin
                    $error("row: expected %0d, got %0d", e.row, o_data.row);
                    errors++;
                end
                if (o_data.col !== e.col) begin
                    $error("col: expected %0d, got %0d", e.col, o_data.col);
                    errors++;
                end
                if (o_data.step_index !== e.step_index) begin
                    $error("step_index: expected %0d, got %0d", e.step_index,
                           o_data.step_index);
                    errors++;
                end
                if (o_data.status !== e.status) begin
                    $error("status: expected %0d, got %0d", e.status, o_data.status);
                    errors++;
                end
                if (o_data.last !== e.last) begin
                    $error("last: expected %0d, got %0d", e.last, o_data.last);
                    errors++;
                end
            end
        end
    end

    // Receiver: random stalls, mostly short; a long hold-off on request.
    initial begin
        int stall;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_ready <= 1'b0;
                repeat (3000) @(posedge i_clk);
                hold_req = 1'b0;
                i_ready <= 1'b1;
            end else begin
                stall = ($urandom_range(0, 99) < 70) ? 0 :
                        ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200)
                                                    : $urandom_range(1, 4);
                if (stall == 0) begin
                    i_ready <= 1'b1;
                end else begin
                    i_ready <= 1'b0;
                    repeat (stall - 1) @(posedge i_clk);
                end
            end
        end
    end

    // Timeout watchdog.
    always @(posedge i_clk) begin
        cyc++;
        if (cyc > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Drop valid, wait until every expected result is in, then let the core settle.
    task automatic drain();
        i_valid <= 1'b0;
        while (tour_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx == CFG_BOARD_SIDE) side_reg = val[3:0];
        else limit_reg = val;
    endtask

    // Offer one start square; hold valid until accepted, then maybe pause.
    task automatic offer(t_in s, bit typed, t_out want);
        int gap;
        i_valid <= 1'b1;
        i_data <= s;
        do @(posedge i_clk); while (!o_ready);
        n_searches++;
        if (typed) tour_q.push_back(want);
        else predict_tour(s);
        gap = ($urandom_range(0, 99) < 60) ? 0 :
              ($urandom_range(0, 9) == 0) ? $urandom_range(30, 300) : $urandom_range(1, 5);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    typedef struct {
        logic [3:0]  side;
        logic [31:0] lim;
        logic [2:0]  r;
        logic [2:0]  c;
        bit          typed;
        logic [1:0]  st;
    } t_row;

    t_row plan[] = '{
        '{4'd8, 32'd0, 3'd0, 3'd0, 1'b0, ST_TOUR},
        '{4'd8, 32'd0, 3'd7, 3'd7, 1'b0, ST_TOUR},
        '{4'd8, 32'd0, 3'd3, 3'd4, 1'b0, ST_TOUR},
        '{4'd0, 32'd0, 3'd0, 3'd0, 1'b0, ST_TOUR},
        '{4'd0, 32'd0, 3'd0, 3'd1, 1'b1, ST_OFFB},
        '{4'd1, 32'd0, 3'd7, 3'd7, 1'b1, ST_OFFB},
        '{4'd2, 32'd0, 3'd0, 3'd0, 1'b1, ST_NOTOUR},
        '{4'd3, 32'd0, 3'd1, 3'd1, 1'b1, ST_NOTOUR},
        '{4'd3, 32'd0, 3'd0, 3'd0, 1'b0, ST_TOUR},
        '{4'd4, 32'd0, 3'd0, 3'd0, 1'b0, ST_TOUR},
        '{4'd5, 32'd0, 3'd0, 3'd0, 1'b0, ST_TOUR},
        '{4'd5, 32'd0, 3'd0, 3'd1, 1'b0, ST_TOUR},
        '{4'd5, 32'd0, 3'd5, 3'd2, 1'b1, ST_OFFB},
        '{4'd5, 32'hFFFFFFFF, 3'd2, 3'd2, 1'b0, ST_TOUR},
        '{4'd6, 32'd1, 3'd0, 3'd0, 1'b1, ST_LIMIT},
        '{4'd6, 32'd36, 3'd5, 3'd5, 1'b0, ST_TOUR},
        '{4'd7, 32'd200, 3'd3, 3'd3, 1'b0, ST_TOUR},
        '{4'd15, 32'd300, 3'd7, 3'd0, 1'b0, ST_TOUR},
        '{4'd9, 32'd64, 3'd0, 3'd7, 1'b0, ST_TOUR},
        '{4'd8, 32'd2, 3'd4, 3'd4, 1'b1, ST_LIMIT},
        '{4'd1, 32'd1, 3'd0, 3'd0, 1'b0, ST_TOUR}
    };

    initial begin
        t_in s;
        t_out w;
        int sd;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table; reconfigure only when the core is idle.
        foreach (plan[i]) begin
            if (plan[i].side != side_reg || plan[i].lim != limit_reg) begin
                drain();
                write_reg(CFG_BOARD_SIDE, {28'd0, plan[i].side});
                write_reg(CFG_STEP_LIMIT, plan[i].lim);
            end
            s.start_row = plan[i].r;
            s.start_col = plan[i].c;
            w = lone(plan[i].st);
            offer(s, plan[i].typed, w);
        end

        // Random phases; big boards always run with a bounded step budget.
        for (int ph = 0; ph < 8; ph++) begin
            drain();
            sd = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(3, 8);
            write_reg(CFG_BOARD_SIDE, sd[31:0]);
            if (sd >= 6 || sd == 0 || $urandom_range(0, 2) == 0)
                write_reg(CFG_STEP_LIMIT, $urandom_range(1, 250));
            else
                write_reg(CFG_STEP_LIMIT, 32'd0);
            if (ph == 3) hold_req = 1'b1;
            for (int n = 0; n < 15; n++) begin
                // Mostly on-board starts so the search gets deep.
                if ($urandom_range(0, 9) < 8 && sd >= 1 && sd <= 8) begin
                    s.start_row = 3'($urandom_range(0, sd - 1));
                    s.start_col = 3'($urandom_range(0, sd - 1));
                end else begin
                    s = 6'($urandom_range(0, 63));
                end
                offer(s, 1'b0, w);
            end
        end

        drain();
        repeat (200) @(posedge i_clk);
        $display("Ran %0d searches (%0d full tours), checked %0d results", n_searches,
                 n_tours, n_results);
        $display("Covered clamped board sides, step limits, off-board starts and no-tour cases");
        if (errors == 0 && tour_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/kts_pkg.sv
rtl/kts_ram.sv
rtl/knights_tour_search_core.sv
rtl/kts_checker.sv
test/tb.sv
